### rtl/raf_pkg.sv
// Shared types and codes for the rational fraction ALU.
`default_nettype none
package raf_pkg;

  localparam int IN_W  = 16;
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  typedef struct packed {
    logic [2:0]      operation;
    logic            left_sign;
    logic [IN_W-1:0] left_numerator;
    logic [IN_W-1:0] left_denominator;
    logic            right_sign;
    logic [IN_W-1:0] right_numerator;
    logic [IN_W-1:0] right_denominator;
  } in_t;

  typedef struct packed {
    logic             result_sign;
    logic [NUM_W-1:0] result_numerator;
    logic [DEN_W-1:0] result_denominator;
    logic             is_equal;
    logic             error;
  } out_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [2:0]      operation;
    logic            bad_op;
    logic            err;
    logic            ls;
    logic [IN_W-1:0] ln;
    logic [IN_W-1:0] ld;
    logic            rs;
    logic [IN_W-1:0] rn;
    logic [IN_W-1:0] rd;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_CHECK,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_NEXT,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

### rtl/raf_front.sv
// Front end: accepts commands, masks and classifies them, two-entry job queue.
`default_nettype none
module raf_front #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire raf_pkg::in_t  cmd,
  output logic               job_valid,
  input  wire logic          job_pop,
  output raf_pkg::job_t      job
);

  localparam int OW = (OPERAND_WIDTH < raf_pkg::IN_W) ? OPERAND_WIDTH : raf_pkg::IN_W;
  localparam logic [raf_pkg::IN_W-1:0] OPND_MASK =
    raf_pkg::IN_W'((33'd1 << OW) - 33'd1);

  raf_pkg::job_t q [2];
  raf_pkg::job_t job_in;
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push;

  assign push      = start && !busy;
  assign busy      = (cnt == 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  always_comb begin
    job_in.operation = cmd.operation;
    job_in.ls        = cmd.left_sign;
    job_in.ln        = cmd.left_numerator & OPND_MASK;
    job_in.ld        = cmd.left_denominator & OPND_MASK;
    job_in.rs        = cmd.right_sign;
    job_in.rn        = cmd.right_numerator & OPND_MASK;
    job_in.rd        = cmd.right_denominator & OPND_MASK;
    job_in.bad_op    = (cmd.operation > raf_pkg::OP_CMP);
    job_in.err       = job_in.bad_op || (job_in.ld == '0) || (job_in.rd == '0) ||
                       ((cmd.operation == raf_pkg::OP_DIV) && (job_in.rn == '0));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (job_pop) begin
        rp <= ~rp;
      end
      case ({push, job_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid) else $error("pop from empty job queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("job queue count out of range");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !job_pop) |=> (cnt == 2'd2)) else $error("full queue lost an entry");

endmodule
`default_nettype wire

### rtl/raf_back.sv
// Back end: cross products, binary GCD and restoring divides, result register.
`default_nettype none
module raf_back #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  output logic                job_pop,
  input  wire raf_pkg::job_t  job,
  output logic                done,
  output raf_pkg::out_t       result
);

  localparam int OW  = (OPERAND_WIDTH < raf_pkg::IN_W) ? OPERAND_WIDTH : raf_pkg::IN_W;
  localparam int PRW = 2 * OW;
  localparam int PW  = 2 * OW + 1;
  localparam int CW  = $clog2(PW + 1);

  raf_pkg::bk_state_t state, state_next;
  raf_pkg::job_t      jb;
  raf_pkg::out_t      result_next;

  logic [PRW-1:0] p1, p2, pd;
  logic           s_sign [2];
  logic [PW-1:0]  s_num  [2];
  logic [PW-1:0]  s_den  [2];
  logic           slot;

  logic [PW-1:0]  ga, gb, g;
  logic [CW-1:0]  gk;
  logic [PW-1:0]  ga_next, gb_next;
  logic [CW-1:0]  gk_next;

  logic [PW-1:0]  dq, dr;
  logic [CW-1:0]  dcnt;
  logic [PW:0]    r_sh;
  logic [PW-1:0]  dq_next, dr_next;

  logic           rsx;
  logic [PW-1:0]  e1, e2;
  logic           gcd_done, div_last, eq;

  assign gcd_done = (ga == '0);
  assign div_last = (dcnt == CW'(PW - 1));
  assign rsx      = jb.rs ^ (jb.operation == raf_pkg::OP_SUB);
  assign e1       = PW'(p1);
  assign e2       = PW'(p2);

  // one binary GCD step
  always_comb begin
    ga_next = ga;
    gb_next = gb;
    gk_next = gk;
    if (!ga[0] && !gb[0]) begin
      ga_next = ga >> 1;
      gb_next = gb >> 1;
      gk_next = gk + CW'(1);
    end else if (!ga[0]) begin
      ga_next = ga >> 1;
    end else if (!gb[0]) begin
      gb_next = gb >> 1;
    end else if (ga >= gb) begin
      ga_next = (ga - gb) >> 1;
    end else begin
      gb_next = (gb - ga) >> 1;
    end
  end

  // one restoring divide step
  always_comb begin
    r_sh    = {dr, dq[PW-1]};
    dq_next = {dq[PW-2:0], 1'b0};
    dr_next = r_sh[PW-1:0];
    if (r_sh >= {1'b0, g}) begin
      dr_next    = PW'(r_sh - {1'b0, g});
      dq_next[0] = 1'b1;
    end
  end

  assign eq = ((s_num[0] == '0) && (s_num[1] == '0)) ||
              ((s_sign[0] == s_sign[1]) && (s_num[0] == s_num[1]) &&
               (s_den[0] == s_den[1]));

  always_comb begin
    result_next       = '0;
    result_next.error = jb.err;
    if (!jb.bad_op) begin
      if (jb.operation == raf_pkg::OP_CMP) begin
        result_next.is_equal = eq;
      end else begin
        result_next.result_sign        = s_sign[0];
        result_next.result_numerator   = raf_pkg::NUM_W'(s_num[0]);
        result_next.result_denominator = raf_pkg::DEN_W'(s_den[0]);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      raf_pkg::BK_IDLE:  if (job_valid) state_next = job.bad_op ? raf_pkg::BK_DONE
                                                                : raf_pkg::BK_MUL;
      raf_pkg::BK_MUL:   state_next = (jb.operation == raf_pkg::OP_CMP) ? raf_pkg::BK_CHECK
                                                                       : raf_pkg::BK_SUM;
      raf_pkg::BK_SUM:   state_next = raf_pkg::BK_CHECK;
      raf_pkg::BK_CHECK: state_next = ((s_num[slot] == '0) || (s_den[slot] == '0))
                                      ? raf_pkg::BK_NEXT : raf_pkg::BK_GCD;
      raf_pkg::BK_GCD:   if (gcd_done) state_next = raf_pkg::BK_DIVN;
      raf_pkg::BK_DIVN:  if (div_last) state_next = raf_pkg::BK_DIVD;
      raf_pkg::BK_DIVD:  if (div_last) state_next = raf_pkg::BK_NEXT;
      raf_pkg::BK_NEXT:  state_next = ((jb.operation == raf_pkg::OP_CMP) && !slot)
                                      ? raf_pkg::BK_CHECK : raf_pkg::BK_DONE;
      raf_pkg::BK_DONE:  state_next = raf_pkg::BK_IDLE;
      default:           state_next = raf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = (state == raf_pkg::BK_IDLE) && job_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= raf_pkg::BK_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == raf_pkg::BK_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      raf_pkg::BK_IDLE: begin
        jb   <= job;
        slot <= 1'b0;
      end
      raf_pkg::BK_MUL: begin
        if (jb.operation == raf_pkg::OP_CMP) begin
          s_sign[0] <= jb.ls;
          s_num[0]  <= PW'(jb.ln[OW-1:0]);
          s_den[0]  <= PW'(jb.ld[OW-1:0]);
          s_sign[1] <= jb.rs;
          s_num[1]  <= PW'(jb.rn[OW-1:0]);
          s_den[1]  <= PW'(jb.rd[OW-1:0]);
        end else if (jb.operation == raf_pkg::OP_MUL) begin
          p1 <= PRW'(jb.ln[OW-1:0]) * PRW'(jb.rn[OW-1:0]);
          pd <= PRW'(jb.ld[OW-1:0]) * PRW'(jb.rd[OW-1:0]);
        end else if (jb.operation == raf_pkg::OP_DIV) begin
          p1 <= PRW'(jb.ln[OW-1:0]) * PRW'(jb.rd[OW-1:0]);
          pd <= PRW'(jb.ld[OW-1:0]) * PRW'(jb.rn[OW-1:0]);
        end else begin
          p1 <= PRW'(jb.ln[OW-1:0]) * PRW'(jb.rd[OW-1:0]);
          p2 <= PRW'(jb.rn[OW-1:0]) * PRW'(jb.ld[OW-1:0]);
          pd <= PRW'(jb.ld[OW-1:0]) * PRW'(jb.rd[OW-1:0]);
        end
      end
      raf_pkg::BK_SUM: begin
        s_den[0] <= PW'(pd);
        if (jb.operation == raf_pkg::OP_MUL || jb.operation == raf_pkg::OP_DIV) begin
          s_num[0]  <= e1;
          s_sign[0] <= jb.ls ^ jb.rs;
        end else if (jb.ls == rsx) begin
          s_num[0]  <= e1 + e2;
          s_sign[0] <= jb.ls;
        end else if (p1 >= p2) begin
          s_num[0]  <= e1 - e2;
          s_sign[0] <= jb.ls;
        end else begin
          s_num[0]  <= e2 - e1;
          s_sign[0] <= rsx;
        end
      end
      raf_pkg::BK_CHECK: begin
        if (s_num[slot] == '0) begin
          s_sign[slot] <= 1'b0;
        end
        ga <= s_num[slot];
        gb <= s_den[slot];
        gk <= '0;
      end
      raf_pkg::BK_GCD: begin
        if (gcd_done) begin
          g    <= gb << gk;
          dq   <= s_num[slot];
          dr   <= '0;
          dcnt <= '0;
        end else begin
          ga <= ga_next;
          gb <= gb_next;
          gk <= gk_next;
        end
      end
      raf_pkg::BK_DIVN: begin
        if (div_last) begin
          s_num[slot] <= dq_next;
          dq          <= s_den[slot];
          dr          <= '0;
          dcnt        <= '0;
        end else begin
          dq   <= dq_next;
          dr   <= dr_next;
          dcnt <= dcnt + CW'(1);
        end
      end
      raf_pkg::BK_DIVD: begin
        if (div_last) begin
          s_den[slot] <= dq_next;
        end else begin
          dq   <= dq_next;
          dr   <= dr_next;
          dcnt <= dcnt + CW'(1);
        end
      end
      raf_pkg::BK_NEXT: begin
        slot <= 1'b1;
      end
      raf_pkg::BK_DONE: begin
        result <= result_next;
      end
      default: begin
      end
    endcase
  end

  a_gcd_b_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == raf_pkg::BK_GCD) |-> (gb != '0)) else $error("gcd operand went to zero");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == raf_pkg::BK_DIVN || state == raf_pkg::BK_DIVD) |-> (g != '0))
    else $error("divide by zero gcd");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held two cycles");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state == raf_pkg::BK_MUL || state == raf_pkg::BK_DONE))
    else $error("job taken outside idle");

endmodule
`default_nettype wire

### rtl/rational_fraction_alu.sv
// Top level of the rational fraction ALU.
//
// Command channel: drive cmd and raise start; the command transfers on a
// rising edge with start high and busy low. busy rises only when the
// two-entry job queue behind the front end is full.
// Result channel: done is high for exactly one cycle with result valid;
// the result transfers at the end of that cycle and cannot be held off.
// Operations: add, subtract, multiply, divide, equality compare. Results are
// reduced by their GCD; a zero numerator leaves the denominator as is and
// forces a positive sign. error flags a zero denominator, division by zero
// or an unknown operation code.
// Per command, with P = 2*min(OPERAND_WIDTH,16)+1 (33 by default): setup and
// product formation, a binary GCD loop, then two restoring divides of P
// quotient bits each, and then the result is registered. Compare runs the
// reduction twice. The back end works on one job at a time and its GCD
// and divider loops set the rate.
// Reset (rst, synchronous) empties the queue and returns the back end to idle.
`default_nettype none
module rational_fraction_alu #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire raf_pkg::in_t  cmd,
  output logic               done,
  output raf_pkg::out_t      result
);

  logic          job_valid;
  logic          job_pop;
  raf_pkg::job_t job;

  raf_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  raf_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .done      (done),
    .result    (result)
  );

endmodule
`default_nettype wire
